### design/linear_adsr_envelope_assert.svh
// Assertion macros for the linear ADSR envelope.
// Expects signals named clock and reset in the including scope.
`ifndef LINEAR_ADSR_ENVELOPE_ASSERT_SVH
`define LINEAR_ADSR_ENVELOPE_ASSERT_SVH

// same-cycle implication
`define ADSR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ADSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/adsr_pkg.sv
// Shared types and constants for the linear ADSR envelope.
// No dependencies.
package adsr_pkg;

   localparam int ACC_SHIFT   = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int PHASE_W     = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ATTACK  = 2'd0,
      CSR_DECAY   = 2'd1,
      CSR_SUSTAIN = 2'd2,
      CSR_RELEASE = 2'd3
   } csr_index_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_OFF     = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_DIV_A = 6'b000010,
      S_DIV_B = 6'b000100,
      S_DIV_C = 6'b001000,
      S_STEP  = 6'b010000,
      S_LEVEL = 6'b100000
   } seq_state_type;

   typedef enum logic [1:0] {
      LVL_ACC  = 2'd0,
      LVL_SUS  = 2'd1,
      LVL_ZERO = 2'd2
   } level_sel_type;

   typedef struct packed {
      logic start;
      logic negate;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

### design/adsr_if.sv
// Handshake channel interfaces for the linear ADSR envelope.
// Depends on adsr_pkg.
interface adsr_req_if ();
   logic valid;
   logic ready;
   logic gate;
   logic block_start;

   modport source (output valid, output gate, output block_start, input ready);
   modport sink (input valid, input gate, input block_start, output ready);
endinterface

interface adsr_rsp_if import adsr_pkg::*; #(parameter int LEVEL_BITS = 24) ();
   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] level;
   logic [PHASE_W-1:0]    phase;

   modport source (output valid, output level, output phase, input ready);
   modport sink (input valid, input level, input phase, output ready);
endinterface

interface adsr_csr_if import adsr_pkg::*; #(parameter int DATA_W = 24) ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### design/adsr_div.sv
// Serial restoring divider, one quotient bit per cycle, signed result.
// Depends on adsr_pkg.
module adsr_div import adsr_pkg::*; #(
   parameter int NUM_W = 42,
   parameter int DEN_W = 18
) (
   input  logic               clock,
   input  logic               reset,
   input  div_ctl_type        ctl,
   input  logic [NUM_W-1:0]   num,
   input  logic [DEN_W-1:0]   den,
   output div_sts_type        sts,
   output logic signed [NUM_W:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] work_ff, work_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, work_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         work_in = num;
         rem_in  = '0;
         den_in  = den;
         neg_in  = ctl.negate;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[NUM_W-2:0], fits};
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, work_ff}) : $signed({1'b0, work_ff});

endmodule

### design/linear_adsr_envelope.sv
// Linear ADSR envelope generator: one item per audio sample tick, one level out.
// Depends on adsr_pkg, adsr_if, adsr_div and linear_adsr_envelope_assert.svh.
//
// Usage:
//   req_bus carries one item per sample tick: gate and block_start. The gate is
//   examined only on items with block_start set.
//   rsp_bus returns one item per request: level (Q1.(LEVEL_BITS-1), saturated
//   to 0..1.0) and phase (off, attack, decay, sustain, release).
//   csr_bus writes attack_samples, decay_samples, sustain_level and
//   release_samples by index; it is always ready. Write only while idle. Values
//   take effect at the next trigger.
//   A plain tick is accepted in idle, then passes through the step and level
//   states. A trigger first adds three divisions on the shared serial divider,
//   one quotient bit per cycle; zero durations skip their division.
//   One item is in work at a time; req_bus.ready is high only when idle.
//   A finished result sits in the output register until taken; a new item may
//   be accepted meanwhile, and its result waits until the register is free.
//   Reset (synchronous) restores the default registers, envelope off, level 0.
`include "linear_adsr_envelope_assert.svh"

module linear_adsr_envelope import adsr_pkg::*; #(
   parameter int COUNT_BITS = 18,
   parameter int LEVEL_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   adsr_req_if.sink    req_bus,
   adsr_rsp_if.source  rsp_bus,
   adsr_csr_if.sink    csr_bus
);
   localparam int AW = LEVEL_BITS + ACC_SHIFT + 3;
   localparam int NW = AW - 1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_FS = LEVEL_BITS'(1) << (LEVEL_BITS - 1);
   localparam logic signed [AW-1:0] ACC_FS = AW'(1) << (LEVEL_BITS - 1 + ACC_SHIFT);
   localparam logic signed [AW-1:0] ACC_LIM = AW'(1) << (LEVEL_BITS + 1 + ACC_SHIFT);
   localparam logic signed [AW:0] ACC_LIM_X = (AW + 1)'(1) << (LEVEL_BITS + 1 + ACC_SHIFT);
   localparam logic signed [AW:0] ACC_NLIM_X = -ACC_LIM_X;

   // configuration
   logic [COUNT_BITS-1:0] cfg_attack_ff, cfg_decay_ff, cfg_release_ff;
   logic [LEVEL_BITS-1:0] cfg_sustain_ff;

   // envelope state
   seq_state_type         state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic                  gate_held_ff, gate_held_in;
   logic signed [AW-1:0]  acc_ff, acc_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic signed [AW-1:0]  attack_step_ff, attack_step_in;
   logic signed [AW-1:0]  decay_step_ff, decay_step_in;
   logic signed [AW-1:0]  release_step_ff, release_step_in;
   logic [COUNT_BITS-1:0] an_ff, an_in, dn_ff, dn_in, rn_ff, rn_in;
   logic [LEVEL_BITS-1:0] sus_ff, sus_in;
   logic                  div_wait_ff, div_wait_in;
   level_sel_type         lvl_sel_ff, lvl_sel_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;
   phase_type             rsp_phase_ff, rsp_phase_in;

   // divider
   div_ctl_type           div_ctl;
   div_sts_type           div_sts;
   logic [NW-1:0]         div_num;
   logic [COUNT_BITS-1:0] div_den;
   logic signed [AW-1:0]  div_quot;

   // trigger helpers
   logic [LEVEL_BITS-1:0] sus_sat;
   logic signed [AW-1:0]  att_diff;
   logic                  att_neg;
   logic [NW-1:0]         att_mag, dec_mag, rel_mag;

   // tick decode
   logic                  step_add;
   logic signed [AW-1:0]  step_sel;
   phase_type             step_phase;
   logic [COUNT_BITS-1:0] step_count;
   level_sel_type         step_lvl;
   logic [COUNT_BITS-1:0] dec_count;
   logic signed [AW:0]    acc_sum;
   logic signed [AW-1:0]  acc_sat;
   logic [AW-ACC_SHIFT-1:0] acc_whole;
   logic [LEVEL_BITS-1:0] acc_level, level_val;

   adsr_div #(.NUM_W(NW), .DEN_W(COUNT_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (div_den),
      .sts   (div_sts),
      .quot  (div_quot)
   );

   assign sus_sat  = (cfg_sustain_ff > LEVEL_FS) ? LEVEL_FS : cfg_sustain_ff;
   assign att_diff = ACC_FS - acc_ff;
   assign att_neg  = att_diff[AW-1];
   assign att_mag  = att_neg ? NW'(-att_diff) : NW'(att_diff);
   assign dec_mag  = NW'({LEVEL_FS - sus_ff, {ACC_SHIFT{1'b0}}});
   assign rel_mag  = NW'({sus_ff, {ACC_SHIFT{1'b0}}});

   // one tick of the envelope, with fall-through between phases
   always_comb begin
      step_add   = 1'b0;
      step_sel   = attack_step_ff;
      step_phase = phase_ff;
      step_count = count_ff;
      step_lvl   = LVL_ZERO;
      dec_count  = (phase_ff == PH_ATTACK) ? '0 : count_ff;
      if (phase_ff == PH_ATTACK && count_ff < an_ff) begin
         step_add   = 1'b1;
         step_count = count_ff + 1'b1;
         step_lvl   = LVL_ACC;
      end else if (phase_ff == PH_ATTACK || phase_ff == PH_DECAY) begin
         if (dec_count < dn_ff) begin
            step_add   = 1'b1;
            step_sel   = decay_step_ff;
            step_count = dec_count + 1'b1;
            step_phase = PH_DECAY;
            step_lvl   = LVL_ACC;
         end else begin
            step_count = '0;
            step_phase = gate_held_ff ? PH_SUSTAIN : PH_RELEASE;
            step_lvl   = LVL_SUS;
         end
      end else if (phase_ff == PH_SUSTAIN) begin
         step_lvl = LVL_SUS;
      end else if (phase_ff == PH_RELEASE && count_ff < rn_ff) begin
         step_add   = 1'b1;
         step_sel   = release_step_ff;
         step_count = count_ff + 1'b1;
         step_lvl   = LVL_ACC;
      end else begin
         if (phase_ff == PH_RELEASE) begin
            step_count = '0;
         end
         step_phase = PH_OFF;
      end
   end

   assign acc_sum = $signed({acc_ff[AW-1], acc_ff}) + $signed({step_sel[AW-1], step_sel});

   always_comb begin
      if (acc_sum > ACC_LIM_X) begin
         acc_sat = ACC_LIM;
      end else if (acc_sum < ACC_NLIM_X) begin
         acc_sat = -ACC_LIM;
      end else begin
         acc_sat = acc_sum[AW-1:0];
      end
   end

   assign acc_whole = acc_ff[AW-1:ACC_SHIFT];

   always_comb begin
      if (acc_ff <= 0) begin
         acc_level = '0;
      end else if (acc_whole > (AW - ACC_SHIFT)'(LEVEL_FS)) begin
         acc_level = LEVEL_FS;
      end else begin
         acc_level = acc_whole[LEVEL_BITS-1:0];
      end
   end

   always_comb begin
      case (lvl_sel_ff)
         LVL_ACC: level_val = acc_level;
         LVL_SUS: level_val = sus_ff;
         default: level_val = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      gate_held_in    = gate_held_ff;
      acc_in          = acc_ff;
      count_in        = count_ff;
      attack_step_in  = attack_step_ff;
      decay_step_in   = decay_step_ff;
      release_step_in = release_step_ff;
      an_in           = an_ff;
      dn_in           = dn_ff;
      rn_in           = rn_ff;
      sus_in          = sus_ff;
      div_wait_in     = div_wait_ff;
      lvl_sel_in      = lvl_sel_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_level_in    = rsp_level_ff;
      rsp_phase_in    = rsp_phase_ff;
      div_ctl         = '0;
      div_num         = att_mag;
      div_den         = an_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               state_in = S_STEP;
               if (req_bus.block_start) begin
                  if (!gate_held_ff) begin
                     if (req_bus.gate) begin
                        sus_in       = sus_sat;
                        an_in        = cfg_attack_ff;
                        dn_in        = cfg_decay_ff;
                        rn_in        = cfg_release_ff;
                        count_in     = '0;
                        phase_in     = PH_ATTACK;
                        gate_held_in = 1'b1;
                        state_in     = S_DIV_A;
                     end
                  end else if (!req_bus.gate) begin
                     gate_held_in = 1'b0;
                     if (phase_ff == PH_SUSTAIN) begin
                        phase_in = PH_RELEASE;
                        count_in = '0;
                     end
                  end
               end
            end
         end
         S_DIV_A: begin
            div_num        = att_mag;
            div_den        = an_ff;
            div_ctl.negate = att_neg;
            if (an_ff == '0) begin
               attack_step_in = '0;
               state_in       = S_DIV_B;
            end else if (!div_wait_ff) begin
               div_ctl.start = 1'b1;
               div_wait_in   = 1'b1;
            end else if (div_sts.done) begin
               attack_step_in = div_quot;
               div_wait_in    = 1'b0;
               state_in       = S_DIV_B;
            end
         end
         S_DIV_B: begin
            div_num        = dec_mag;
            div_den        = dn_ff;
            div_ctl.negate = 1'b1;
            if (dn_ff == '0) begin
               decay_step_in = '0;
               state_in      = S_DIV_C;
            end else if (!div_wait_ff) begin
               div_ctl.start = 1'b1;
               div_wait_in   = 1'b1;
            end else if (div_sts.done) begin
               decay_step_in = div_quot;
               div_wait_in   = 1'b0;
               state_in      = S_DIV_C;
            end
         end
         S_DIV_C: begin
            div_num        = rel_mag;
            div_den        = rn_ff;
            div_ctl.negate = 1'b1;
            if (rn_ff == '0) begin
               release_step_in = '0;
               state_in        = S_STEP;
            end else if (!div_wait_ff) begin
               div_ctl.start = 1'b1;
               div_wait_in   = 1'b1;
            end else if (div_sts.done) begin
               release_step_in = div_quot;
               div_wait_in     = 1'b0;
               state_in        = S_STEP;
            end
         end
         S_STEP: begin
            if (step_add) begin
               acc_in = acc_sat;
            end
            phase_in   = step_phase;
            count_in   = step_count;
            lvl_sel_in = step_lvl;
            state_in   = S_LEVEL;
         end
         S_LEVEL: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_val;
               rsp_phase_in = phase_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         phase_ff        <= PH_OFF;
         gate_held_ff    <= 1'b0;
         acc_ff          <= '0;
         count_ff        <= '0;
         attack_step_ff  <= '0;
         decay_step_ff   <= '0;
         release_step_ff <= '0;
         an_ff           <= '0;
         dn_ff           <= '0;
         rn_ff           <= '0;
         sus_ff          <= '0;
         div_wait_ff     <= 1'b0;
         lvl_sel_ff      <= LVL_ZERO;
         rsp_valid_ff    <= 1'b0;
         cfg_attack_ff   <= COUNT_BITS'(4800);
         cfg_decay_ff    <= COUNT_BITS'(4800);
         cfg_sustain_ff  <= LEVEL_BITS'(1) << (LEVEL_BITS - 2);
         cfg_release_ff  <= COUNT_BITS'(24000);
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         gate_held_ff    <= gate_held_in;
         acc_ff          <= acc_in;
         count_ff        <= count_in;
         attack_step_ff  <= attack_step_in;
         decay_step_ff   <= decay_step_in;
         release_step_ff <= release_step_in;
         an_ff           <= an_in;
         dn_ff           <= dn_in;
         rn_ff           <= rn_in;
         sus_ff          <= sus_in;
         div_wait_ff     <= div_wait_in;
         lvl_sel_ff      <= lvl_sel_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_bus.valid) begin
            case (csr_index_type'(csr_bus.index))
               CSR_ATTACK:  cfg_attack_ff  <= csr_bus.data[COUNT_BITS-1:0];
               CSR_DECAY:   cfg_decay_ff   <= csr_bus.data[COUNT_BITS-1:0];
               CSR_SUSTAIN: cfg_sustain_ff <= csr_bus.data[LEVEL_BITS-1:0];
               CSR_RELEASE: cfg_release_ff <= csr_bus.data[COUNT_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_level_ff <= rsp_level_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.level = rsp_level_ff;
   assign rsp_bus.phase = rsp_phase_ff;

   `ADSR_ASSERT_NOW(a_idle_div_quiet, req_bus.ready, !div_sts.busy,
      "divider busy while accepting an item")
   `ADSR_ASSERT_NEXT(a_div_starts, div_ctl.start, div_sts.busy,
      "divider did not start")
   `ADSR_ASSERT_NOW(a_level_range, rsp_bus.valid, rsp_bus.level <= LEVEL_FS,
      "level above full scale")
   `ADSR_ASSERT_NOW(a_attack_count, phase_ff == PH_ATTACK, count_ff <= an_ff,
      "attack count beyond duration")
   `ADSR_ASSERT_NOW(a_acc_range, 1'b1, (acc_ff <= ACC_LIM) && (acc_ff >= -ACC_LIM),
      "accumulator outside saturation range")

endmodule
